// ===== rtl/point_to_pixel_projection_defines.svh =====
// Assertion macros shared by the projection RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef POINT_TO_PIXEL_PROJECTION_DEFINES_SVH
`define POINT_TO_PIXEL_PROJECTION_DEFINES_SVH

// Checks that cond_a implies cond_b in the same cycle.
`define P2P_ASSERT_NOW(lbl, clk_s, rst_s, cond_a, cond_b) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (cond_a) |-> (cond_b)) \
    else $error("concurrent check failed");

// Checks that cond_a implies cond_b in the cycle after.
`define P2P_ASSERT_NEXT(lbl, clk_s, rst_s, cond_a, cond_b) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (cond_a) |=> (cond_b)) \
    else $error("concurrent check failed");

`endif

// ===== rtl/p2p_pkg.sv =====
// Shared constants and types of the point to pixel projection block.
// Depends on nothing; imported by the interfaces and all modules.
package p2p_pkg;

  localparam int IMAGE_WIDTH_DEF  = 1280;
  localparam int IMAGE_HEIGHT_DEF = 720;

  localparam int NUM_REGS   = 8;
  localparam int NUM_ROWS   = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int COORD_W    = 32;
  localparam int PROD_W     = 64;
  localparam int PAIR_W     = 65;
  localparam int ACC_W      = 66;
  localparam int MAG_W      = 65;
  localparam int PIX_COL_W  = 11;
  localparam int PIX_ROW_W  = 10;

  // Row order inside the accumulator arrays.
  localparam int ROW_COL   = 0;
  localparam int ROW_ROW   = 1;
  localparam int ROW_DEPTH = 2;
  localparam int ROW_FRONT = 3;

  typedef struct packed {
    logic [MAG_W-1:0] mag_col;
    logic [MAG_W-1:0] mag_row;
    logic [MAG_W-1:0] mag_depth;
    logic             neg_col;
    logic             neg_row;
    logic             ok;
    logic             last;
  } div_req_t;

  typedef struct packed {
    logic [PIX_COL_W-1:0] col;
    logic [PIX_ROW_W-1:0] row;
    logic                 in_view;
    logic                 last;
  } pix_result_t;

endpackage

// ===== rtl/p2p_if.sv =====
// Stream interfaces for the point input and pixel result channels.
// Depends on p2p_pkg for field widths.
interface p2p_in_if import p2p_pkg::*;;
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] point_x;
  logic [COORD_W-1:0] point_y;
  logic [COORD_W-1:0] point_z;
  logic               point_last;
  modport source (output valid, point_x, point_y, point_z, point_last, input ready);
  modport sink   (input valid, point_x, point_y, point_z, point_last, output ready);
endinterface

interface p2p_out_if import p2p_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [PIX_COL_W-1:0] pixel_col;
  logic [PIX_ROW_W-1:0] pixel_row;
  logic                 in_view;
  logic                 result_last;
  modport source (output valid, pixel_col, pixel_row, in_view, result_last, input ready);
  modport sink   (input valid, pixel_col, pixel_row, in_view, result_last, output ready);
endinterface

// ===== rtl/p2p_div_pipe.sv =====
// Pipelined restoring divider that yields column and row, one quotient bit per stage.
// Depends on p2p_pkg for the request and result types.
module p2p_div_pipe import p2p_pkg::*; #(
  parameter int IMAGE_WIDTH  = IMAGE_WIDTH_DEF,
  parameter int IMAGE_HEIGHT = IMAGE_HEIGHT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        req_valid,
  output logic        req_ready,
  input  div_req_t    req,
  output logic        res_valid,
  input  logic        res_ready,
  output pix_result_t res
);

  localparam int QB_COL = $clog2(IMAGE_WIDTH);
  localparam int QB_ROW = $clog2(IMAGE_HEIGHT);
  localparam int QB     = (QB_COL > QB_ROW) ? QB_COL : QB_ROW;
  localparam int DW     = MAG_W + QB;

  typedef struct packed {
    logic neg_col;
    logic neg_row;
    logic ovf_col;
    logic ovf_row;
    logic ok;
    logic last;
  } div_info_t;

  logic             v_r    [0:QB];
  logic [MAG_W-1:0] rem0_r [0:QB];
  logic [MAG_W-1:0] rem1_r [0:QB];
  logic [MAG_W-1:0] d_r    [0:QB];
  logic [QB-1:0]    q0_r   [0:QB];
  logic [QB-1:0]    q1_r   [0:QB];
  div_info_t        info_r [0:QB];
  logic             en     [0:QB+1];

  assign en[QB+1] = res_ready;
  for (genvar k = 0; k <= QB; k++) begin : g_en
    assign en[k] = !v_r[k] || en[k+1];
  end
  assign req_ready = en[0];

  // Stage 0: a numerator at or above the divisor shifted by QB has too many quotient bits.
  logic [DW-1:0] d_top;
  assign d_top = DW'(req.mag_depth) << QB;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en[0]) begin
      v_r[0] <= req_valid;
    end
    if (en[0]) begin
      rem0_r[0]         <= req.mag_col;
      rem1_r[0]         <= req.mag_row;
      d_r[0]            <= req.mag_depth;
      q0_r[0]           <= '0;
      q1_r[0]           <= '0;
      info_r[0].neg_col <= req.neg_col;
      info_r[0].neg_row <= req.neg_row;
      info_r[0].ovf_col <= DW'(req.mag_col) >= d_top;
      info_r[0].ovf_row <= DW'(req.mag_row) >= d_top;
      info_r[0].ok      <= req.ok;
      info_r[0].last    <= req.last;
    end
  end

  for (genvar k = 1; k <= QB; k++) begin : g_step
    localparam int J = QB - k;
    logic [DW-1:0] dsh;
    logic [DW-1:0] r0w;
    logic [DW-1:0] r1w;
    logic          ge0;
    logic          ge1;
    assign dsh = DW'(d_r[k-1]) << J;
    assign r0w = DW'(rem0_r[k-1]);
    assign r1w = DW'(rem1_r[k-1]);
    assign ge0 = r0w >= dsh;
    assign ge1 = r1w >= dsh;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en[k]) begin
        v_r[k] <= v_r[k-1];
      end
      if (en[k]) begin
        rem0_r[k] <= ge0 ? MAG_W'(r0w - dsh) : rem0_r[k-1];
        rem1_r[k] <= ge1 ? MAG_W'(r1w - dsh) : rem1_r[k-1];
        q0_r[k]   <= q0_r[k-1] | (ge0 ? (QB'(1) << J) : '0);
        q1_r[k]   <= q1_r[k-1] | (ge1 ? (QB'(1) << J) : '0);
        d_r[k]    <= d_r[k-1];
        info_r[k] <= info_r[k-1];
      end
    end
  end

  // A nonzero quotient with opposite signs is a negative coordinate.
  logic col_ok;
  logic row_ok;
  logic view;
  assign col_ok = !info_r[QB].ovf_col
               && ({1'b0, q0_r[QB]} < (QB+1)'(IMAGE_WIDTH))
               && (q0_r[QB] == '0 || !info_r[QB].neg_col);
  assign row_ok = !info_r[QB].ovf_row
               && ({1'b0, q1_r[QB]} < (QB+1)'(IMAGE_HEIGHT))
               && (q1_r[QB] == '0 || !info_r[QB].neg_row);
  assign view   = info_r[QB].ok && col_ok && row_ok;

  assign res_valid   = v_r[QB];
  assign res.in_view = view;
  assign res.col     = view ? PIX_COL_W'(q0_r[QB]) : '0;
  assign res.row     = view ? PIX_ROW_W'(q1_r[QB]) : '0;
  assign res.last    = info_r[QB].last;

endmodule

// ===== rtl/point_to_pixel_projection.sv =====
// Stages: multiply, two add stages, magnitude, a divider overflow check, then one
// divider stage per quotient bit and an output register; one point per cycle while the
// output is ready, each stage advancing whenever its successor frees.
// Reset (synchronous, rst_n low) clears all valid bits and the eight configuration registers to 0.
// Depends on p2p_pkg, p2p_if, p2p_div_pipe and the assertion macro header.
`include "point_to_pixel_projection_defines.svh"
module point_to_pixel_projection import p2p_pkg::*; #(
  parameter int IMAGE_WIDTH  = IMAGE_WIDTH_DEF,
  parameter int IMAGE_HEIGHT = IMAGE_HEIGHT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  p2p_in_if.sink                in_chan,
  p2p_out_if.source             out_chan,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [CFG_DATA_W-1:0] cfg_regs_r [0:NUM_REGS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) cfg_regs_r[i] <= '0;
    end else if (cfg_we) begin
      cfg_regs_r[cfg_index] <= cfg_data;
    end
  end

  logic v1_r, v2_r, v3_r, v4_r;
  logic en1, en2, en3, en4, en_out;
  logic div_ready;
  logic div_valid;
  pix_result_t div_res;
  logic out_valid_r;
  pix_result_t out_r;

  assign en_out = !out_valid_r || out_chan.ready;
  assign en4    = !v4_r || div_ready;
  assign en3    = !v3_r || en4;
  assign en2    = !v2_r || en3;
  assign en1    = !v1_r || en2;
  assign in_chan.ready = en1;

  logic signed [PROD_W-1:0] prod_r [0:NUM_ROWS-1][0:2];
  logic signed [PAIR_W-1:0] pa_r   [0:NUM_ROWS-1];
  logic signed [PAIR_W-1:0] pb_r   [0:NUM_ROWS-1];
  logic signed [ACC_W-1:0]  sum_r  [0:NUM_ROWS-1];
  logic last1_r, last2_r, last3_r;
  div_req_t req_r;

  logic signed [COORD_W-1:0] px, py, pz;
  assign px = in_chan.point_x;
  assign py = in_chan.point_y;
  assign pz = in_chan.point_z;

  for (genvar r = 0; r < NUM_ROWS; r++) begin : g_row
    logic signed [COORD_W-1:0] c0, c1, c2, off;
    logic signed [PROD_W-1:0]  m0, m1, m2;
    logic signed [PAIR_W-1:0]  off_w;
    assign c0  = cfg_regs_r[2*r][31:0];
    assign c1  = cfg_regs_r[2*r][63:32];
    assign c2  = cfg_regs_r[2*r+1][31:0];
    assign off = cfg_regs_r[2*r+1][63:32];
    assign m0  = c0 * px;
    assign m1  = c1 * py;
    assign m2  = c2 * pz;
    // The offset is Q16.16 and the products Q32.32, so it moves up by 16 bits.
    assign off_w = PAIR_W'(off) <<< 16;

    always_ff @(posedge clk) begin
      if (en1) begin
        prod_r[r][0] <= m0;
        prod_r[r][1] <= m1;
        prod_r[r][2] <= m2;
      end
      if (en2) begin
        pa_r[r] <= PAIR_W'(prod_r[r][0]) + PAIR_W'(prod_r[r][1]);
        pb_r[r] <= PAIR_W'(prod_r[r][2]) + off_w;
      end
      if (en3) begin
        sum_r[r] <= ACC_W'(pa_r[r]) + ACC_W'(pb_r[r]);
      end
    end
  end

  logic [ACC_W-1:0] abs_col, abs_row, abs_depth;
  logic             neg_col, neg_row, neg_depth, neg_front;
  assign neg_col   = sum_r[ROW_COL][ACC_W-1];
  assign neg_row   = sum_r[ROW_ROW][ACC_W-1];
  assign neg_depth = sum_r[ROW_DEPTH][ACC_W-1];
  assign neg_front = sum_r[ROW_FRONT][ACC_W-1];
  assign abs_col   = neg_col ? -sum_r[ROW_COL] : sum_r[ROW_COL];
  assign abs_row   = neg_row ? -sum_r[ROW_ROW] : sum_r[ROW_ROW];
  assign abs_depth = neg_depth ? -sum_r[ROW_DEPTH] : sum_r[ROW_DEPTH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en1)    v1_r        <= in_chan.valid;
      if (en2)    v2_r        <= v1_r;
      if (en3)    v3_r        <= v2_r;
      if (en4)    v4_r        <= v3_r;
      if (en_out) out_valid_r <= div_valid;
    end
    if (en1) last1_r <= in_chan.point_last;
    if (en2) last2_r <= last1_r;
    if (en3) last3_r <= last2_r;
    if (en4) begin
      req_r.mag_col   <= abs_col[MAG_W-1:0];
      req_r.mag_row   <= abs_row[MAG_W-1:0];
      req_r.mag_depth <= abs_depth[MAG_W-1:0];
      req_r.neg_col   <= neg_col != neg_depth;
      req_r.neg_row   <= neg_row != neg_depth;
      req_r.ok        <= !neg_front && (sum_r[ROW_FRONT] != '0)
                      && (sum_r[ROW_DEPTH] != '0);
      req_r.last      <= last3_r;
    end
    if (en_out) out_r <= div_res;
  end

  p2p_div_pipe #(
    .IMAGE_WIDTH  (IMAGE_WIDTH),
    .IMAGE_HEIGHT (IMAGE_HEIGHT)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (v4_r),
    .req_ready (div_ready),
    .req       (req_r),
    .res_valid (div_valid),
    .res_ready (en_out),
    .res       (div_res)
  );

  assign out_chan.valid       = out_valid_r;
  assign out_chan.pixel_col   = out_r.col;
  assign out_chan.pixel_row   = out_r.row;
  assign out_chan.in_view     = out_r.in_view;
  assign out_chan.result_last = out_r.last;

  `P2P_ASSERT_NOW(a_col_range, clk, rst_n, out_chan.valid && out_chan.in_view,
                  32'(out_chan.pixel_col) < IMAGE_WIDTH)
  `P2P_ASSERT_NOW(a_zero_when_out, clk, rst_n, out_chan.valid && !out_chan.in_view,
                  out_chan.pixel_col == '0 && out_chan.pixel_row == '0)
  `P2P_ASSERT_NOW(a_ready_when_empty, clk, rst_n, !out_chan.valid, in_chan.ready)

endmodule
